// ===== hdl/u8dv_pkg.sv =====
// Package for the strict UTF-8 stream decoder and validator.
// Holds the item types of both channels and the second-byte range classes.
// No dependencies.
package u8dv_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        has_code_point;
        logic        end_of_buffer;
        logic        buffer_valid;
        logic [15:0] char_count;
    } out_item_t;

    // allowed range of the second byte of a sequence
    localparam logic [2:0] CLS_80_BF = 3'd0;
    localparam logic [2:0] CLS_A0_BF = 3'd1;
    localparam logic [2:0] CLS_80_9F = 3'd2;
    localparam logic [2:0] CLS_90_BF = 3'd3;
    localparam logic [2:0] CLS_80_8F = 3'd4;

    localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;
    localparam int          OUT_COUNT_BITS = 16;

endpackage

// ===== hdl/utf8_stream_decode_validate_core.sv =====
// Top level of the strict UTF-8 stream decoder and validator.
// Depends on u8dv_pkg.
//
// Usage:
//   s_ channel carries one byte per item plus a flag for the last byte of a
//   buffer. m_ channel carries one item per completed code point and one for
//   the last byte of every buffer (both on the same item where they coincide).
//   The end-of-buffer item reports whether the whole buffer was strict UTF-8
//   and how many code points it held (saturating at 65535 for COUNT_BITS >= 16).
//   Decoding state is updated in the cycle a byte is accepted; the result
//   lands in the output register (or the skid register if the receiver
//   stalls). Throughput is one byte per cycle while s_ready is high, set by
//   the state update and the two-entry output buffer.
//   When the receiver stalls, one further result is held in a skid register;
//   s_ready drops only once both output entries are full.
//   Reset (aresetn low, synchronous) empties the output buffer and clears the
//   decoder state and character count. After the last byte of each buffer
//   the same state is cleared for the next buffer.
module utf8_stream_decode_validate_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  u8dv_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output u8dv_pkg::out_item_t m_data
);
    import u8dv_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [1:0]            bytes_left_reg, bytes_left_upd, bytes_left_next;
    logic [20:0]           partial_reg, partial_upd, partial_next;
    logic [2:0]            class_reg, class_upd, class_next;
    logic                  at_second_reg, at_second_upd, at_second_next;
    logic                  failed_reg, failed_upd, failed_next;
    logic [COUNT_BITS-1:0] count_reg, count_upd, count_next;

    logic        s_fire, m_fire, produce;
    logic        have;
    logic [20:0] cp;
    logic [20:0] shifted;
    logic        cont_ok;
    logic [7:0]  b;
    logic [15:0] count_rep;
    out_item_t   res;

    out_item_t out_reg, skid_reg;
    logic      out_valid_reg, skid_valid_reg;

    assign b       = s_data.data_byte;
    assign s_ready = !skid_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign m_fire  = out_valid_reg && m_ready;
    assign shifted = {partial_reg[14:0], b[5:0]};

    always_comb begin
        case (class_reg)
            CLS_A0_BF: cont_ok = (b >= 8'hA0) && (b <= 8'hBF);
            CLS_80_9F: cont_ok = (b >= 8'h80) && (b <= 8'h9F);
            CLS_90_BF: cont_ok = (b >= 8'h90) && (b <= 8'hBF);
            CLS_80_8F: cont_ok = (b >= 8'h80) && (b <= 8'h8F);
            default:   cont_ok = (b >= 8'h80) && (b <= 8'hBF);
        endcase
        if (!at_second_reg) begin
            cont_ok = (b[7:6] == 2'b10);
        end
    end

    always_comb begin
        bytes_left_upd = bytes_left_reg;
        partial_upd    = partial_reg;
        class_upd      = class_reg;
        at_second_upd  = at_second_reg;
        failed_upd     = failed_reg;
        count_upd      = count_reg;
        have           = 1'b0;
        cp             = '0;
        if (!failed_reg) begin
            if (bytes_left_reg == 2'd0) begin
                at_second_upd = 1'b1;
                if (b <= 8'h7F) begin
                    have          = 1'b1;
                    cp            = {13'd0, b};
                    at_second_upd = at_second_reg;
                end else if ((b >= 8'hC2) && (b <= 8'hDF)) begin
                    bytes_left_upd = 2'd1;
                    partial_upd    = {16'd0, b[4:0]};
                    class_upd      = CLS_80_BF;
                end else if (b == 8'hE0) begin
                    bytes_left_upd = 2'd2;
                    partial_upd    = {17'd0, b[3:0]};
                    class_upd      = CLS_A0_BF;
                end else if (b == 8'hED) begin
                    bytes_left_upd = 2'd2;
                    partial_upd    = {17'd0, b[3:0]};
                    class_upd      = CLS_80_9F;
                end else if ((b >= 8'hE1) && (b <= 8'hEF)) begin
                    bytes_left_upd = 2'd2;
                    partial_upd    = {17'd0, b[3:0]};
                    class_upd      = CLS_80_BF;
                end else if (b == 8'hF0) begin
                    bytes_left_upd = 2'd3;
                    partial_upd    = {18'd0, b[2:0]};
                    class_upd      = CLS_90_BF;
                end else if (b == 8'hF4) begin
                    bytes_left_upd = 2'd3;
                    partial_upd    = {18'd0, b[2:0]};
                    class_upd      = CLS_80_8F;
                end else if ((b >= 8'hF1) && (b <= 8'hF3)) begin
                    bytes_left_upd = 2'd3;
                    partial_upd    = {18'd0, b[2:0]};
                    class_upd      = CLS_80_BF;
                end else begin
                    failed_upd    = 1'b1;
                    at_second_upd = at_second_reg;
                end
            end else if (!cont_ok) begin
                failed_upd = 1'b1;
            end else begin
                at_second_upd  = 1'b0;
                bytes_left_upd = bytes_left_reg - 2'd1;
                if (bytes_left_reg == 2'd1) begin
                    have        = 1'b1;
                    cp          = shifted;
                    partial_upd = '0;
                    class_upd   = CLS_80_BF;
                end else begin
                    partial_upd = shifted;
                end
            end
            if (have && (count_reg != COUNT_MAX)) begin
                count_upd = count_reg + 1'b1;
            end
        end
    end

    generate
        if (COUNT_BITS > OUT_COUNT_BITS) begin : g_sat
            assign count_rep = (|count_upd[COUNT_BITS-1:OUT_COUNT_BITS]) ?
                               {OUT_COUNT_BITS{1'b1}} : count_upd[OUT_COUNT_BITS-1:0];
        end else begin : g_ext
            assign count_rep = OUT_COUNT_BITS'(count_upd);
        end
    endgenerate

    always_comb begin
        res.code_point     = cp;
        res.has_code_point = have;
        res.end_of_buffer  = s_data.last_byte;
        res.buffer_valid   = s_data.last_byte && !failed_upd && (bytes_left_upd == 2'd0);
        res.char_count     = count_rep;
        produce            = s_fire && (have || s_data.last_byte);
        if (s_data.last_byte) begin
            bytes_left_next = '0;
            partial_next    = '0;
            class_next      = CLS_80_BF;
            at_second_next  = 1'b0;
            failed_next     = 1'b0;
            count_next      = '0;
        end else begin
            bytes_left_next = bytes_left_upd;
            partial_next    = partial_upd;
            class_next      = class_upd;
            at_second_next  = at_second_upd;
            failed_next     = failed_upd;
            count_next      = count_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            partial_reg    <= '0;
            class_reg      <= CLS_80_BF;
            at_second_reg  <= 1'b0;
            failed_reg     <= 1'b0;
            count_reg      <= '0;
        end else if (s_fire) begin
            bytes_left_reg <= bytes_left_next;
            partial_reg    <= partial_next;
            class_reg      <= class_next;
            at_second_reg  <= at_second_next;
            failed_reg     <= failed_next;
            count_reg      <= count_next;
        end
    end

    // two-entry output buffer: out_reg faces the receiver, skid_reg catches overflow
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_fire) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= produce;
                end
            end else if (produce) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_fire) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (produce) begin
                out_reg <= res;
            end
        end else if (produce) begin
            skid_reg <= res;
        end
    end

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_item_has_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.has_code_point || m_data.end_of_buffer))
        else $error("result item with neither code point nor end of buffer");

    a_scalar_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.has_code_point) |->
            ((m_data.code_point <= MAX_SCALAR) &&
             ((m_data.code_point < 21'hD800) || (m_data.code_point > 21'hDFFF))))
        else $error("decoded value is not a Unicode scalar value");

    a_valid_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.buffer_valid) |-> m_data.end_of_buffer)
        else $error("buffer_valid set away from end of buffer");

endmodule
